// File: src/gki_pkg.sv
// ----------------------------------------------------------------------------
// gki_pkg
// shared types and constants of the keyframe seek index
// ----------------------------------------------------------------------------
package gki_pkg;

    localparam int MAX_PACKETS = 65536;
    localparam int MAX_GOPS    = 4096;
    localparam int TIME_BITS   = 48;
    localparam int PKT_AW      = $clog2(MAX_PACKETS);
    localparam int GOP_AW      = $clog2(MAX_GOPS);

    typedef enum logic [2:0] {
        ACT_APPEND   = 3'd0,
        ACT_FINISH   = 3'd1,
        ACT_KEY_TIME = 3'd2,
        ACT_PKT_TIME = 3'd3,
        ACT_GOP_TIME = 3'd4,
        ACT_CLEAR    = 3'd5,
        ACT_GOP_PKT  = 3'd6,
        ACT_NOP      = 3'd7
    } t_action;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  stream_num;
        logic [47:0] pts_ticks;
        logic        pts_present;
        logic [47:0] dts_ticks;
        logic        dts_present;
        logic        is_keyframe;
        logic [23:0] byte_size;
        logic [47:0] target_time;
        logic [15:0] target_packet;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] packet_index;
        logic [11:0] gop_index;
        logic [16:0] packet_count;
        logic [12:0] gop_count;
        logic [16:0] longest_gop_frames;
        logic [46:0] longest_gop_ticks;
        logic [47:0] byte_total;
    } t_out;

endpackage

// File: src/gki_if.sv
// ----------------------------------------------------------------------------
// gki_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface gki_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/gop_keyframe_index_top.sv
// ----------------------------------------------------------------------------
// gop_keyframe_index_top
// keyframe seek index over one video stream with binary search queries
// ----------------------------------------------------------------------------
// usage: commands arrive on the input channel, one result per command leaves
// on the output channel. the cfg channel writes the indexed stream number
// and must be written by the user only while the block is idle; the block does not enforce it.
// a keyframe append reads the open group first to close it, and finish
// also closes the open group. queries are binary searches with one memory
// read per probe; gop queries add one more read for the gop start.
// one command is in work at a time; the result sits in an output register
// and the next command is taken once the previous result is transferred.
// a stalled receiver holds the result and blocks new commands.
// reset clears counts, maxima and totals; table memories are not cleared
// and only entries below the counts are ever used.
// ----------------------------------------------------------------------------
module gop_keyframe_index_top
    import gki_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    gki_if.sink   cfg,
    gki_if.sink   in_ch,
    gki_if.source out_ch
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_CLOSE = 8'b00000010,
        S_CLW   = 8'b00000100,
        S_PROBE = 8'b00001000,
        S_PWAIT = 8'b00010000,
        S_FINAL = 8'b00100000,
        S_FWAIT = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state r_state;
    t_in    r_cmd;
    t_out   r_res;
    logic   r_ovalid;

    logic [7:0]        r_stream;
    logic [PKT_AW:0]   r_pkts;
    logic [GOP_AW:0]   r_gops;
    logic [47:0]       r_last;
    logic [PKT_AW:0]   r_maxf;
    logic [46:0]       r_maxd;
    logic [47:0]       r_bytes;

    // search state
    logic [PKT_AW+1:0] r_lo, r_hi, r_res_i;
    logic [PKT_AW+1:0] r_mid;
    logic              r_close_then_app;

    // memories
    logic              pt_we, gp_we, gt_we;
    logic [PKT_AW-1:0] pt_addr;
    logic [GOP_AW-1:0] g_addr;
    logic [47:0]       pt_wd, pt_rd, gt_wd, gt_rd;
    logic [15:0]       gp_wd, gp_rd;

    gki_ram #(.WIDTH(48), .DEPTH(MAX_PACKETS)) u_pt (
        .i_clk(i_clk), .i_we(pt_we), .i_addr(pt_addr), .i_wdata(pt_wd), .o_rdata(pt_rd));
    gki_ram #(.WIDTH(16), .DEPTH(MAX_GOPS)) u_gp (
        .i_clk(i_clk), .i_we(gp_we), .i_addr(g_addr), .i_wdata(gp_wd), .o_rdata(gp_rd));
    gki_ram #(.WIDTH(48), .DEPTH(MAX_GOPS)) u_gt (
        .i_clk(i_clk), .i_we(gt_we), .i_addr(g_addr), .i_wdata(gt_wd), .o_rdata(gt_rd));

    assign cfg.ready    = 1'b1;
    assign in_ch.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_res;

    logic        take;
    logic [47:0] t_pkt;
    logic        mine, full, is_gop_q;
    logic [PKT_AW-1:0] pk_lo;
    assign take  = in_ch.valid && in_ch.ready;
    assign t_pkt = r_cmd.pts_present ? r_cmd.pts_ticks :
                   (r_cmd.dts_present ? r_cmd.dts_ticks : 48'd0);
    assign mine  = r_cmd.stream_num == r_stream;
    assign full  = (r_pkts >= (PKT_AW+1)'(MAX_PACKETS)) ||
                   (r_cmd.is_keyframe && (r_gops >= (GOP_AW+1)'(MAX_GOPS)));
    assign is_gop_q = (r_cmd.action == ACT_KEY_TIME) || (r_cmd.action == ACT_GOP_TIME)
                   || (r_cmd.action == ACT_GOP_PKT);
    assign pk_lo = r_pkts[PKT_AW-1:0];

    // command decode
    t_state     n_state;
    logic [1:0] n_status;
    logic       n_close_then_app;

    always_comb begin
        n_state = S_OUT;
        n_status = ST_OK;
        n_close_then_app = 1'b0;
        case (t_action'(r_cmd.action))
            ACT_APPEND: begin
                if (mine) begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_close_then_app = 1'b1;
                        n_state = S_CLW;
                    end
                end
            end
            ACT_FINISH: n_state = S_CLW;
            ACT_PKT_TIME: begin
                if (r_pkts == '0) n_status = ST_EMPTY;
                else n_state = S_PROBE;
            end
            ACT_KEY_TIME, ACT_GOP_TIME, ACT_GOP_PKT: begin
                if (r_gops == '0) n_status = ST_EMPTY;
                else n_state = S_PROBE;
            end
            default: ;
        endcase
    end

    // close arithmetic on read data
    logic [PKT_AW:0] frames;
    logic [48:0]     dur;
    logic [46:0]     dcap;
    assign frames = r_pkts - (PKT_AW+1)'(gp_rd);
    assign dur    = {r_last[47], r_last} - {gt_rd[47], gt_rd};
    assign dcap   = dur[48] ? 47'd0 : ((dur[47:47] != 1'b0) ? {47{1'b1}} : dur[46:0]);

    // probe compare
    logic pt_less, g_le;
    assign pt_less = $signed(pt_rd) < $signed(r_cmd.target_time);
    assign g_le    = (r_cmd.action == ACT_GOP_PKT) ? (gp_rd <= r_cmd.target_packet)
                                                   : ($signed(gt_rd) <= $signed(r_cmd.target_time));

    logic [PKT_AW+1:0] mid_c;
    assign mid_c = (r_lo + r_hi) >> 1;

    logic [48:0] bsum;
    assign bsum = {1'b0, r_bytes} + 49'(r_cmd.byte_size);

    always_comb begin
        pt_we = 1'b0; gp_we = 1'b0; gt_we = 1'b0;
        pt_addr = pk_lo; g_addr = r_gops[GOP_AW-1:0] - 1'b1;
        pt_wd = t_pkt; gp_wd = 16'(r_pkts); gt_wd = t_pkt;
        case (r_state)
            S_PROBE: begin
                pt_addr = mid_c[PKT_AW-1:0];
                g_addr  = mid_c[GOP_AW-1:0];
            end
            S_FINAL: begin
                g_addr = r_res_i[GOP_AW-1:0];
            end
            S_CLW: begin
                if (r_close_then_app) begin
                    pt_we = 1'b1;
                    if (r_cmd.is_keyframe) begin
                        gp_we = 1'b1; gt_we = 1'b1;
                        g_addr = r_gops[GOP_AW-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0; r_stream <= '0;
            r_pkts <= '0; r_gops <= '0; r_last <= '0; r_maxf <= '0;
            r_maxd <= '0; r_bytes <= '0; r_close_then_app <= 1'b0;
        end else begin
            if (cfg.valid) r_stream <= cfg.data;
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_cmd <= in_ch.data;
                        r_state <= S_CLOSE;
                    end
                end
                S_CLOSE: begin
                    r_res.status       <= n_status;
                    r_res.packet_index <= '0;
                    r_res.gop_index    <= '0;
                    r_close_then_app   <= n_close_then_app;
                    r_state            <= n_state;
                    case (t_action'(r_cmd.action))
                        ACT_CLEAR: begin
                            r_pkts <= '0; r_gops <= '0; r_last <= '0;
                            r_maxf <= '0; r_maxd <= '0; r_bytes <= '0;
                        end
                        ACT_PKT_TIME: begin
                            r_lo <= '0; r_hi <= (PKT_AW+2)'(r_pkts);
                        end
                        ACT_KEY_TIME, ACT_GOP_TIME, ACT_GOP_PKT: begin
                            r_lo <= '0; r_hi <= (PKT_AW+2)'(r_gops) - 1'b1;
                            r_res_i <= '0;
                        end
                        default: ;
                    endcase
                end
                S_CLW: begin
                    // gop read data valid here: close open group
                    if (r_gops != '0 && r_pkts != '0 &&
                        (!r_close_then_app || r_cmd.is_keyframe)) begin
                        if (frames > r_maxf) r_maxf <= frames;
                        if (dcap > r_maxd) r_maxd <= dcap;
                    end
                    if (r_close_then_app) begin
                        if (r_cmd.is_keyframe) r_gops <= r_gops + 1'b1;
                        r_pkts  <= r_pkts + 1'b1;
                        r_last  <= t_pkt;
                        r_bytes <= bsum[48] ? {48{1'b1}} : bsum[47:0];
                    end
                    r_state <= S_OUT;
                end
                S_PROBE: begin
                    // lower bound uses [lo,hi), gop searches use [lo,hi]
                    if ((is_gop_q && ($signed(r_lo) > $signed(r_hi))) ||
                        (!is_gop_q && r_lo >= r_hi)) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_mid <= mid_c;
                        r_state <= S_PWAIT;
                    end
                end
                S_PWAIT: begin
                    if (is_gop_q) begin
                        if (g_le) begin
                            r_res_i <= r_mid; r_lo <= r_mid + 1'b1;
                        end else r_hi <= r_mid - 1'b1;
                    end else begin
                        if (pt_less) r_lo <= r_mid + 1'b1;
                        else r_hi <= r_mid;
                    end
                    r_state <= S_PROBE;
                end
                S_FINAL: begin
                    if (is_gop_q) r_state <= S_FWAIT;
                    else begin
                        r_res.packet_index <= (r_lo >= (PKT_AW+2)'(r_pkts)) ?
                            16'(r_pkts - 1'b1) : 16'(r_lo);
                        r_state <= S_OUT;
                    end
                end
                S_FWAIT: begin
                    r_res.gop_index    <= 12'(r_res_i);
                    r_res.packet_index <= gp_rd;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_res.packet_count       <= 17'(r_pkts);
                    r_res.gop_count          <= 13'(r_gops);
                    r_res.longest_gop_frames <= 17'(r_maxf);
                    r_res.longest_gop_ticks  <= r_maxd;
                    r_res.byte_total         <= r_bytes;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: src/gki_ram.sv
// ----------------------------------------------------------------------------
// gki_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module gki_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
